// ===== src/hrrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hrrt_pkg;

   // Structural defaults
   localparam int TRIM_WINDOW_DEFAULT   = 5;
   localparam int HISTORY_DEPTH_DEFAULT = 3;
   localparam int RESTING_DEPTH_DEFAULT = 3;

   // Event codes
   localparam logic [2:0] FUNC_SAMPLE  = 3'd0;
   localparam logic [2:0] FUNC_TIMEOUT = 3'd1;
   localparam logic [2:0] FUNC_START   = 3'd2;
   localparam logic [2:0] FUNC_JUDGE   = 3'd3;
   localparam logic [2:0] FUNC_OPEN    = 3'd4;
   localparam logic [2:0] FUNC_CLOSE   = 3'd5;
   localparam logic [2:0] FUNC_CLEAR   = 3'd6;

   // Sensor commands
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_START_INTERVAL = 3'd0;
   localparam logic [2:0] REG_JUDGE_INTERVAL = 3'd1;
   localparam logic [2:0] REG_REST_PERIODS   = 3'd2;
   localparam logic [2:0] REG_OFF_TOUCH      = 3'd3;
   localparam logic [2:0] REG_UPPER_LIMIT    = 3'd4;
   localparam logic [2:0] REG_FLOOR          = 3'd5;
   localparam logic [2:0] REG_MAX_SPREAD     = 3'd6;

   // Register reset values
   localparam logic [7:0]  START_INTERVAL_RESET = 8'd2;
   localparam logic [7:0]  JUDGE_INTERVAL_RESET = 8'd6;
   localparam logic [15:0] REST_PERIODS_RESET   = 16'd3;
   localparam logic [7:0]  OFF_TOUCH_RESET      = 8'd3;
   localparam logic [7:0]  UPPER_LIMIT_RESET    = 8'd120;
   localparam logic [7:0]  FLOOR_RESET          = 8'd30;
   localparam logic [7:0]  MAX_SPREAD_RESET     = 8'd80;

   localparam logic [7:0] RATE_NONE = 8'hFF;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  heart_rate;
      logic        touching;
      logic [15:0] step_total;
   } req_type;

   typedef struct packed {
      logic [7:0] log_heart_rate;
      logic [7:0] resting_heart_rate;
      logic       monitoring_active;
      logic [1:0] sensor_command;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/heart_rate_rest_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Heart rate rest tracker. Every request transaction is one event (second sample,
// window timeout, start minute, judge minute, open, close, clear) and returns exactly
// one response transaction with the logged rate, the resting rate, the active flag
// and a sensor command. One event is taken per clock while request ready is high; its
// response is registered, and the rate is set by the combinational state update
// (trimmed window mean, history minimum and candidate average all resolve in one
// pass). A result register plus a one-entry skid buffer let a new request in
// while an earlier response still waits; request ready drops only when both hold
// data. Configuration registers sit on an APB-style port at byte address 4*index
// and must only be written while the block is idle.
module heart_rate_rest_tracker #(
   parameter int TRIM_WINDOW   = hrrt_pkg::TRIM_WINDOW_DEFAULT,
   parameter int HISTORY_DEPTH = hrrt_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int RESTING_DEPTH = hrrt_pkg::RESTING_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire hrrt_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      hrrt_pkg::rsp_type rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [4:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output      logic [31:0]       prdata,
   output      logic              pready
);

   import hrrt_pkg::*;

   localparam int TRIM_DIVISOR = TRIM_WINDOW - 2;
   localparam int WIN_FILL_W   = $clog2(TRIM_WINDOW + 1);
   localparam int HIST_FILL_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int CAND_FILL_W  = $clog2(RESTING_DEPTH + 1);
   localparam int WIN_SUM_W    = 8 + $clog2(TRIM_WINDOW);
   localparam int CAND_SUM_W   = 8 + $clog2(RESTING_DEPTH);

   // Divide by a small constant through a rounded-up reciprocal; three spare
   // fraction bits keep the floor exact for every divisor up to eight.
   localparam int WIN_DIV_SHIFT  = WIN_SUM_W + 3;
   localparam int WIN_DIV_RECIP  = ((1 << WIN_DIV_SHIFT) + TRIM_DIVISOR - 1) / TRIM_DIVISOR;
   localparam int WIN_PROD_W     = WIN_SUM_W + WIN_DIV_SHIFT;
   localparam int CAND_DIV_SHIFT = CAND_SUM_W + 3;
   localparam int CAND_DIV_RECIP =
      ((1 << CAND_DIV_SHIFT) + RESTING_DEPTH - 1) / RESTING_DEPTH;
   localparam int CAND_PROD_W    = CAND_SUM_W + CAND_DIV_SHIFT;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [7:0]  start_interval_ff, judge_interval_ff, off_touch_limit_ff;
   logic [7:0]  upper_limit_ff, floor_ff, max_spread_ff;
   logic [15:0] rest_periods_ff;
   logic        cfg_write;
   logic [2:0]  cfg_index;

   assign pready    = 1'b1;
   assign cfg_index = paddr[4:2];
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_interval_ff  <= START_INTERVAL_RESET;
         judge_interval_ff  <= JUDGE_INTERVAL_RESET;
         rest_periods_ff    <= REST_PERIODS_RESET;
         off_touch_limit_ff <= OFF_TOUCH_RESET;
         upper_limit_ff     <= UPPER_LIMIT_RESET;
         floor_ff           <= FLOOR_RESET;
         max_spread_ff      <= MAX_SPREAD_RESET;
      end else if (cfg_write) begin
         case (cfg_index)
            REG_START_INTERVAL: start_interval_ff  <= pwdata[7:0];
            REG_JUDGE_INTERVAL: judge_interval_ff  <= pwdata[7:0];
            REG_REST_PERIODS:   rest_periods_ff    <= pwdata[15:0];
            REG_OFF_TOUCH:      off_touch_limit_ff <= pwdata[7:0];
            REG_UPPER_LIMIT:    upper_limit_ff     <= pwdata[7:0];
            REG_FLOOR:          floor_ff           <= pwdata[7:0];
            REG_MAX_SPREAD:     max_spread_ff      <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         REG_START_INTERVAL: prdata = {24'd0, start_interval_ff};
         REG_JUDGE_INTERVAL: prdata = {24'd0, judge_interval_ff};
         REG_REST_PERIODS:   prdata = {16'd0, rest_periods_ff};
         REG_OFF_TOUCH:      prdata = {24'd0, off_touch_limit_ff};
         REG_UPPER_LIMIT:    prdata = {24'd0, upper_limit_ff};
         REG_FLOOR:          prdata = {24'd0, floor_ff};
         REG_MAX_SPREAD:     prdata = {24'd0, max_spread_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Tracker state
   // ---------------------------------------------------------------------------
   logic [7:0]             win_ff [TRIM_WINDOW];
   logic [7:0]             win_in [TRIM_WINDOW];
   logic [WIN_FILL_W-1:0]  win_fill_ff, win_fill_in;
   logic [7:0]             hist_ff [HISTORY_DEPTH];
   logic [7:0]             hist_in [HISTORY_DEPTH];
   logic [HIST_FILL_W-1:0] hist_fill_ff, hist_fill_in;
   logic [7:0]             cand_ff [RESTING_DEPTH];
   logic [7:0]             cand_in [RESTING_DEPTH];
   logic [CAND_FILL_W-1:0] cand_fill_ff, cand_fill_in;
   logic [7:0]             off_touch_ff, off_touch_in;
   logic                   active_ff, active_in;
   logic [15:0]            still_ff, still_in;
   logic [15:0]            last_steps_ff, last_steps_in;
   logic                   first_judge_ff, first_judge_in;
   logic [7:0]             logged_ff, logged_in;
   logic [7:0]             resting_ff, resting_in;
   logic [7:0]             start_div_ff, start_div_in;
   logic [7:0]             judge_div_ff, judge_div_in;
   logic [1:0]             cmd;

   // datapath helpers
   logic                   touch_lost;
   logic [7:0]             win_max, win_min, hist_min, spread, avg_rate, win_avg;
   logic [WIN_SUM_W-1:0]   win_sum, win_trim;
   logic [WIN_PROD_W-1:0]  win_prod;
   logic [CAND_SUM_W-1:0]  cand_sum;
   logic [CAND_PROD_W-1:0] cand_prod;

   // handshake
   logic    accept, rsp_taken;
   logic    skid_valid_ff;
   rsp_type skid_ff;
   rsp_type rsp_data_ff;
   rsp_type result;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_taken = rsp_valid && rsp_ready;

   assign touch_lost = !req_data.touching && (off_touch_ff >= off_touch_limit_ff);

   // Trimmed window mean: whole window, stale entries included.
   always_comb begin
      win_max = win_ff[0];
      win_min = win_ff[0];
      win_sum = '0;
      for (int k = 0; k < TRIM_WINDOW; k++) begin
         if (win_ff[k] > win_max) win_max = win_ff[k];
         if (win_ff[k] < win_min) win_min = win_ff[k];
         win_sum = win_sum + WIN_SUM_W'(win_ff[k]);
      end
      win_trim = win_sum - WIN_SUM_W'(win_max) - WIN_SUM_W'(win_min);
      win_prod = WIN_PROD_W'(win_trim) * WIN_PROD_W'(WIN_DIV_RECIP);
      win_avg  = win_prod[WIN_DIV_SHIFT +: 8];
   end

   // History minimum and candidate statistics for the judge step.
   always_comb begin
      hist_min = hist_ff[0];
      for (int k = 1; k < HISTORY_DEPTH; k++) begin
         if (hist_ff[k] < hist_min) hist_min = hist_ff[k];
      end
      cand_sum = '0;
      for (int k = 0; k < RESTING_DEPTH; k++) begin
         cand_sum = cand_sum + CAND_SUM_W'(cand_ff[k]);
      end
      cand_prod = CAND_PROD_W'(cand_sum) * CAND_PROD_W'(CAND_DIV_RECIP);
      avg_rate  = cand_prod[CAND_DIV_SHIFT +: 8];
      if (cand_ff[RESTING_DEPTH-1] >= cand_ff[0]) begin
         spread = cand_ff[RESTING_DEPTH-1] - cand_ff[0];
      end else begin
         spread = cand_ff[0] - cand_ff[RESTING_DEPTH-1];
      end
   end

   // Next-state logic for one event.
   always_comb begin
      win_in        = win_ff;
      win_fill_in   = win_fill_ff;
      hist_in       = hist_ff;
      hist_fill_in  = hist_fill_ff;
      cand_in       = cand_ff;
      cand_fill_in  = cand_fill_ff;
      off_touch_in  = off_touch_ff;
      active_in     = active_ff;
      still_in      = still_ff;
      last_steps_in = last_steps_ff;
      first_judge_in = first_judge_ff;
      logged_in     = logged_ff;
      resting_in    = resting_ff;
      start_div_in  = start_div_ff;
      judge_div_in  = judge_div_ff;
      cmd           = CMD_NONE;

      case (req_data.func)
         FUNC_SAMPLE: begin
            if (active_ff) begin
               if (touch_lost) begin
                  logged_in = 8'd0;
                  active_in = 1'b0;
                  cmd       = CMD_STOP;
               end else begin
                  if (off_touch_ff != 8'hFF) off_touch_in = off_touch_ff + 8'd1;
                  // push into window, sliding once full
                  if (win_fill_ff >= WIN_FILL_W'(TRIM_WINDOW)) begin
                     for (int k = 0; k < TRIM_WINDOW - 1; k++) win_in[k] = win_ff[k+1];
                     win_in[TRIM_WINDOW-1] = req_data.heart_rate;
                  end else begin
                     for (int k = 0; k < TRIM_WINDOW; k++) begin
                        if (WIN_FILL_W'(k) == win_fill_ff) win_in[k] = req_data.heart_rate;
                     end
                     win_fill_in = win_fill_ff + WIN_FILL_W'(1);
                  end
               end
            end
         end
         FUNC_TIMEOUT: begin
            if (active_ff) begin
               active_in = 1'b0;
               cmd       = CMD_STOP;
               if (touch_lost) begin
                  logged_in = 8'd0;
               end else begin
                  if (hist_fill_ff >= HIST_FILL_W'(HISTORY_DEPTH)) begin
                     for (int k = 0; k < HISTORY_DEPTH - 1; k++) hist_in[k] = hist_ff[k+1];
                     hist_in[HISTORY_DEPTH-1] = req_data.heart_rate;
                  end else begin
                     for (int k = 0; k < HISTORY_DEPTH; k++) begin
                        if (HIST_FILL_W'(k) == hist_fill_ff) hist_in[k] = req_data.heart_rate;
                     end
                     hist_fill_in = hist_fill_ff + HIST_FILL_W'(1);
                  end
                  logged_in = win_avg;
               end
            end
         end
         FUNC_START: begin
            if (start_div_ff != 8'hFF) start_div_in = start_div_ff + 8'd1;
            if (start_div_in >= start_interval_ff) begin
               start_div_in = 8'd0;
               win_fill_in  = '0;
               off_touch_in = 8'd0;
               active_in    = 1'b1;
               cmd          = CMD_START;
            end
         end
         FUNC_JUDGE: begin
            if (judge_div_ff != 8'hFF) judge_div_in = judge_div_ff + 8'd1;
            if (judge_div_in >= judge_interval_ff) begin
               judge_div_in = 8'd0;
               if (first_judge_ff) begin
                  first_judge_in = 1'b0;
                  still_in       = 16'd0;
                  last_steps_in  = req_data.step_total;
               end else begin
                  if (req_data.step_total != last_steps_ff) begin
                     still_in      = 16'd0;
                     last_steps_in = req_data.step_total;
                  end else if (still_ff != 16'hFFFF) begin
                     still_in = still_ff + 16'd1;
                  end
                  if (hist_fill_ff >= HIST_FILL_W'(HISTORY_DEPTH)) begin
                     if (cand_fill_ff < CAND_FILL_W'(RESTING_DEPTH)) begin
                        // collect another candidate
                        for (int k = 0; k < RESTING_DEPTH; k++) begin
                           if (CAND_FILL_W'(k) == cand_fill_ff) cand_in[k] = hist_min;
                        end
                        cand_fill_in = cand_fill_ff + CAND_FILL_W'(1);
                     end else if (spread > max_spread_ff) begin
                        // too much drift: start over
                        still_in       = 16'd0;
                        first_judge_in = 1'b1;
                        cand_fill_in   = '0;
                        hist_fill_in   = '0;
                     end else if (still_in >= rest_periods_ff) begin
                        if (avg_rate < upper_limit_ff) begin
                           if (avg_rate < floor_ff) begin
                              if (floor_ff < resting_ff) resting_in = floor_ff;
                           end else if (avg_rate < resting_ff) begin
                              resting_in = avg_rate;
                           end
                        end
                        still_in       = 16'd0;
                        first_judge_in = 1'b1;
                        cand_fill_in   = '0;
                        hist_fill_in   = '0;
                     end
                  end
               end
            end
         end
         FUNC_OPEN: begin
            cand_fill_in   = '0;
            logged_in      = 8'd0;
            still_in       = 16'd0;
            last_steps_in  = 16'd0;
            first_judge_in = 1'b1;
            hist_fill_in   = '0;
            win_fill_in    = '0;
            off_touch_in   = 8'd0;
            active_in      = 1'b1;
            for (int k = 0; k < RESTING_DEPTH; k++) cand_in[k] = 8'd0;
            for (int k = 0; k < HISTORY_DEPTH; k++) hist_in[k] = 8'd0;
            cmd = CMD_START;
         end
         FUNC_CLOSE: begin
            active_in = 1'b0;
            cmd       = CMD_STOP;
         end
         FUNC_CLEAR: begin
            resting_in = RATE_NONE;
            logged_in  = RATE_NONE;
         end
         default: ;
      endcase

      result.log_heart_rate     = logged_in;
      result.resting_heart_rate = resting_in;
      result.monitoring_active  = active_in;
      result.sensor_command     = cmd;
   end

   // Commit state on every accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TRIM_WINDOW; k++) win_ff[k] <= 8'd0;
         for (int k = 0; k < HISTORY_DEPTH; k++) hist_ff[k] <= 8'd0;
         for (int k = 0; k < RESTING_DEPTH; k++) cand_ff[k] <= 8'd0;
         win_fill_ff    <= '0;
         hist_fill_ff   <= '0;
         cand_fill_ff   <= '0;
         off_touch_ff   <= 8'd0;
         active_ff      <= 1'b0;
         still_ff       <= 16'd0;
         last_steps_ff  <= 16'd0;
         first_judge_ff <= 1'b1;
         logged_ff      <= RATE_NONE;
         resting_ff     <= RATE_NONE;
         start_div_ff   <= 8'd0;
         judge_div_ff   <= 8'd0;
      end else if (accept) begin
         win_ff         <= win_in;
         hist_ff        <= hist_in;
         cand_ff        <= cand_in;
         win_fill_ff    <= win_fill_in;
         hist_fill_ff   <= hist_fill_in;
         cand_fill_ff   <= cand_fill_in;
         off_touch_ff   <= off_touch_in;
         active_ff      <= active_in;
         still_ff       <= still_in;
         last_steps_ff  <= last_steps_in;
         first_judge_ff <= first_judge_in;
         logged_ff      <= logged_in;
         resting_ff     <= resting_in;
         start_div_ff   <= start_div_in;
         judge_div_ff   <= judge_div_in;
      end
   end

   // Response register with a one-entry skid behind it.
   logic rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!rsp_valid_ff || rsp_taken) begin
            // output slot frees up: refill from skid first, else from a new event
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_taken) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_ff;
         end else if (accept) begin
            rsp_data_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

endmodule

`default_nettype wire
